// ----- rtl/token_scanner_macros.svh -----
// ----------------------------------------------------------------------------
// token_scanner_macros.svh
// Assertion shorthands shared by the token scanner checks. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TOKEN_SCANNER_MACROS_SVH
`define TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token_scanner: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token_scanner: next-cycle check failed");

`endif

// ----- rtl/tsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, token codes, character classes and the token request
// record used by the token scanner modules.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // Parameter defaults.
    localparam int DEF_PREFIX_CHARS  = 8;
    localparam int DEF_MAX_TOKEN_LEN = 255;

    // Fixed field widths.
    localparam int KIND_W = 5;
    localparam int POS_W  = 20;
    localparam int LEN_W  = 8;
    localparam int TEXT_W = 64;
    localparam int INT_W  = 63;
    localparam int ERR_W  = 2;
    localparam int TAB_W  = 5;

    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(4);

    // Result queue depth (power of two, at least two).
    localparam int FIFO_DEPTH = 4;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_SYM0    = 5'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_INT     = 5'd17;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_EOF     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_INVALID = 5'd20;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TRAIL_DOT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INT_RANGE = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 2'd3;

    // Special characters.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Single-character symbols : ; = + - * / % ( ) in kind order.
    localparam int SYM_COUNT = 10;
    localparam logic [7:0] SYM_CHARS [SYM_COUNT] = '{
        8'h3A, 8'h3B, 8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h28, 8'h29
    };

    // Keywords let, int, float, bool, true, false; first character lowest.
    // The misspelling "flase" matches none of them and stays an identifier.
    localparam int KW_COUNT = 6;
    localparam int KW_BITS  = 40;
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        40'h000074656C, 40'h0000746E69, 40'h74616F6C66,
        40'h006C6F6F62, 40'h0065757274, 40'h65736C6166
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5};

    // Output stream packing, lowest field first.
    localparam int OFS_LINE   = 0;
    localparam int OFS_COL    = OFS_LINE + POS_W;
    localparam int OFS_LEN    = OFS_COL + POS_W;
    localparam int OFS_TEXT   = OFS_LEN + LEN_W;
    localparam int OFS_INT    = OFS_TEXT + TEXT_W;
    localparam int OFS_ERR    = OFS_INT + INT_W;
    localparam int DATA_BITS  = OFS_ERR + ERR_W;
    localparam int M_TDATA_W  = ((DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  column;
        logic [LEN_W-1:0]  length;
        logic [TEXT_W-1:0] prefix;
        logic [INT_W-1:0]  value;
        logic [ERR_W-1:0]  error;
        logic              last;
    } tsc_result_t;

    // Up to two tokens produced by one byte, the finished token first.
    typedef struct packed {
        logic [1:0]  count;
        tsc_result_t res_first;
        tsc_result_t res_second;
    } tsc_push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic tsc_result_t make_result(
        input logic [KIND_W-1:0] kind,
        input logic [POS_W-1:0]  line,
        input logic [POS_W-1:0]  column,
        input logic [LEN_W-1:0]  length,
        input logic [TEXT_W-1:0] prefix,
        input logic [INT_W-1:0]  value,
        input logic [ERR_W-1:0]  error
    );
        tsc_result_t r;
        r.kind   = kind;
        r.line   = line;
        r.column = column;
        r.length = length;
        r.prefix = prefix;
        r.value  = value;
        r.error  = error;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/tsc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_core
// Scanner state and the per-byte step logic. One registered byte is consumed
// per enabled cycle and yields zero, one or two token requests.
// ----------------------------------------------------------------------------
module tsc_core
    import tsc_pkg::*;
#(
    parameter int PREFIX_CHARS  = DEF_PREFIX_CHARS,
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [TAB_W-1:0] cfg_wdata,
    input  logic             step_en,
    input  logic [7:0]       char_code,
    input  logic             end_of_input,
    output tsc_push_t        push
);

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
    localparam int TXT_BITS = 8 * PREFIX_CHARS;
    localparam int PROD_W   = INT_W + 4;
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);
    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    logic [TAB_W-1:0]    tab_width_reg;
    logic [1:0]          mode_reg,  mode_next;
    logic [POS_W-1:0]    line_reg,  line_next;
    logic [POS_W-1:0]    col_reg,   col_next;
    logic [POS_W-1:0]    tline_reg, tline_next;
    logic [POS_W-1:0]    tcol_reg,  tcol_next;
    logic [LEN_BITS-1:0] tlen_reg,  tlen_next;
    logic [TXT_BITS-1:0] ttext_reg, ttext_next;
    logic [INT_W-1:0]    acc_reg,   acc_next;
    logic                ovf_reg,   ovf_next;
    logic                dot_reg,   dot_next;
    logic                ewd_reg,   ewd_next;

    logic                c_alpha, c_digit, c_space, c_under, c_dot;
    logic                sym_hit;
    logic [KIND_W-1:0]   sym_kind;
    logic [POS_W-1:0]    col_inc, col_tab, adv_line, adv_col;
    logic [POS_W:0]      tab_sum;
    logic [LEN_BITS-1:0] add_len;
    logic [TXT_BITS-1:0] add_text;
    logic [PROD_W-1:0]   prod;
    logic                acc_ovf;
    logic                kw_found;
    logic [KIND_W-1:0]   kw_kind;
    tsc_result_t         fin_id, fin_num, idle_res, eof_res, dot_res;
    tsc_result_t         res_a, res_b;
    logic [1:0]          cnt;
    logic                run_idle;

    // Character classes of the current byte.
    always_comb
    begin
        c_alpha  = is_alpha(char_code);
        c_digit  = is_digit(char_code);
        c_space  = is_space(char_code);
        c_under  = (char_code == CH_UNDER);
        c_dot    = (char_code == CH_DOT);
        sym_hit  = 1'b0;
        sym_kind = KIND_SYM0;
        for (int i = 0; i < SYM_COUNT; i++)
        begin
            if (!sym_hit && char_code == SYM_CHARS[i])
            begin
                sym_hit  = 1'b1;
                sym_kind = KIND_SYM0 + KIND_W'(i);
            end
        end
    end

    // Position advance over the current byte, saturating.
    always_comb
    begin
        col_inc  = (col_reg != POS_MAX) ? col_reg + POS_ONE : col_reg;
        tab_sum  = {1'b0, col_reg} + (POS_W + 1)'(tab_width_reg);
        col_tab  = (tab_sum > {1'b0, POS_MAX}) ? POS_MAX : tab_sum[POS_W-1:0];
        adv_line = line_reg;
        adv_col  = col_inc;
        if (char_code == CH_NL)
        begin
            adv_line = (line_reg != POS_MAX) ? line_reg + POS_ONE : line_reg;
            adv_col  = POS_ONE;
        end
        else if (char_code == CH_TAB)
        begin
            adv_col = col_tab;
        end
    end

    // Append the byte to the token text and length.
    always_comb
    begin
        add_len  = (tlen_reg != LEN_MAX) ? tlen_reg + LEN_ONE : tlen_reg;
        add_text = ttext_reg;
        for (int i = 0; i < PREFIX_CHARS; i++)
        begin
            if (tlen_reg == LEN_BITS'(i))
            begin
                add_text[8*i +: 8] = char_code;
            end
        end
    end

    // Decimal accumulate; the sum exceeds the signed 64-bit range when any
    // bit above the low 63 is set.
    always_comb
    begin
        prod    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + PROD_W'(char_code[3:0]);
        acc_ovf = |prod[PROD_W-1:INT_W];
    end

    // Keyword lookup on the stored identifier.
    always_comb
    begin
        kw_found = 1'b0;
        kw_kind  = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (!kw_found && tlen_reg == LEN_BITS'(KW_LEN[i])
                && ttext_reg[KW_BITS-1:0] == KW_TEXT[i])
            begin
                kw_found = 1'b1;
                kw_kind  = KIND_W'(i);
            end
        end
    end

    // Candidate tokens.
    always_comb
    begin
        if (kw_found)
        begin
            fin_id = make_result(kw_kind, tline_reg, tcol_reg, '0, '0, '0, ERR_NONE);
        end
        else
        begin
            fin_id = make_result(KIND_IDENT, tline_reg, tcol_reg, LEN_W'(tlen_reg),
                                 TEXT_W'(ttext_reg), '0, ERR_NONE);
        end

        if (ewd_reg)
        begin
            fin_num = make_result(KIND_INVALID, tline_reg, tcol_reg, LEN_W'(tlen_reg),
                                  TEXT_W'(ttext_reg), '0, ERR_TRAIL_DOT);
        end
        else if (dot_reg)
        begin
            fin_num = make_result(KIND_FLOAT, tline_reg, tcol_reg, LEN_W'(tlen_reg),
                                  TEXT_W'(ttext_reg), '0, ERR_NONE);
        end
        else if (ovf_reg)
        begin
            fin_num = make_result(KIND_INVALID, tline_reg, tcol_reg, LEN_W'(tlen_reg),
                                  TEXT_W'(ttext_reg), '0, ERR_INT_RANGE);
        end
        else
        begin
            fin_num = make_result(KIND_INT, tline_reg, tcol_reg, LEN_W'(tlen_reg),
                                  TEXT_W'(ttext_reg), acc_reg, ERR_NONE);
        end

        if (sym_hit)
        begin
            idle_res = make_result(sym_kind, line_reg, col_reg, '0, '0, '0, ERR_NONE);
        end
        else
        begin
            idle_res = make_result(KIND_INVALID, line_reg, col_reg, '0, '0, '0, ERR_BAD_CHAR);
        end

        eof_res = make_result(KIND_EOF, line_reg, col_inc, '0, '0, '0, ERR_NONE);
        dot_res = make_result(KIND_INVALID, tline_reg, tcol_reg, LEN_W'(add_len),
                              TEXT_W'(add_text), '0, ERR_TRAIL_DOT);
    end

    // Step: next state and the tokens of this byte.
    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        tlen_next  = tlen_reg;
        ttext_next = ttext_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        dot_next   = dot_reg;
        ewd_next   = ewd_reg;
        res_a      = '0;
        res_b      = '0;
        cnt        = 2'd0;
        run_idle   = 1'b0;

        if (end_of_input)
        begin
            // Close any open token, then report end of file.
            if (mode_reg == MODE_IDENT)
            begin
                res_a = fin_id;
                cnt   = 2'd1;
            end
            else if (mode_reg == MODE_NUMBER)
            begin
                res_a = fin_num;
                cnt   = 2'd1;
            end
            if (cnt == 2'd0)
            begin
                res_a = eof_res;
            end
            else
            begin
                res_b = eof_res;
            end
            cnt       = cnt + 2'd1;
            mode_next = MODE_IDLE;
            line_next = POS_ONE;
            col_next  = POS_ONE;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (c_alpha || c_digit || c_under)
                    begin
                        tlen_next  = add_len;
                        ttext_next = add_text;
                        line_next  = adv_line;
                        col_next   = adv_col;
                    end
                    else
                    begin
                        res_a    = fin_id;
                        cnt      = 2'd1;
                        run_idle = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (c_digit)
                    begin
                        if (!dot_reg && !ovf_reg)
                        begin
                            if (acc_ovf)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = prod[INT_W-1:0];
                            end
                        end
                        ewd_next   = 1'b0;
                        tlen_next  = add_len;
                        ttext_next = add_text;
                        line_next  = adv_line;
                        col_next   = adv_col;
                    end
                    else if (c_dot && !ewd_reg)
                    begin
                        tlen_next  = add_len;
                        ttext_next = add_text;
                        line_next  = adv_line;
                        col_next   = adv_col;
                        ewd_next   = 1'b1;
                        if (dot_reg)
                        begin
                            // A second dot closes the literal as invalid.
                            res_a     = dot_res;
                            cnt       = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            dot_next = 1'b1;
                        end
                    end
                    else
                    begin
                        res_a    = fin_num;
                        cnt      = 2'd1;
                        run_idle = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            // Between tokens: skip space, open a token or emit a one-byte token.
            if (run_idle)
            begin
                mode_next = MODE_IDLE;
                line_next = adv_line;
                col_next  = adv_col;
                if (c_space)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c_alpha || c_under || c_digit)
                begin
                    mode_next  = c_digit ? MODE_NUMBER : MODE_IDENT;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    tlen_next  = LEN_ONE;
                    ttext_next = TXT_BITS'(char_code);
                    acc_next   = c_digit ? INT_W'(char_code[3:0]) : '0;
                    ovf_next   = 1'b0;
                    dot_next   = 1'b0;
                    ewd_next   = 1'b0;
                end
                else
                begin
                    if (cnt == 2'd0)
                    begin
                        res_a = idle_res;
                    end
                    else
                    begin
                        res_b = idle_res;
                    end
                    cnt = cnt + 2'd1;
                end
            end
        end

        // Mark the last token of this byte.
        if (cnt == 2'd1)
        begin
            res_a.last = 1'b1;
        end
        if (cnt == 2'd2)
        begin
            res_b.last = 1'b1;
        end
    end

    assign push.count      = step_en ? cnt : 2'd0;
    assign push.res_first  = res_a;
    assign push.res_second = res_b;

    // Tab width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            tab_width_reg <= cfg_wdata;
        end
    end

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            tline_reg <= POS_ONE;
            tcol_reg  <= POS_ONE;
            tlen_reg  <= '0;
            ttext_reg <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            dot_reg   <= 1'b0;
            ewd_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            tlen_reg  <= tlen_next;
            ttext_reg <= ttext_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            dot_reg   <= dot_next;
            ewd_reg   <= ewd_next;
        end
    end

endmodule

// ----- rtl/tsc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_fifo
// Token queue: takes up to two token requests per cycle, hands out one per
// cycle while popped, and reports room for a full two-token step.
// ----------------------------------------------------------------------------
module tsc_fifo
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tsc_push_t   push,
    input  logic        pop,
    output tsc_result_t head,
    output logic        not_empty,
    output logic        room
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

    tsc_result_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = (pop && not_empty) ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop && not_empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage; the second token lands one slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res_first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_ONE] <= push.res_second;
        end
    end

endmodule

// ----- rtl/token_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_scanner
// Streaming lexical scanner: source bytes in, tokens with position, text
// prefix, literal value and error code out.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per clock cycle while the output queue has
// room; a byte with tlast set closes the source, flushes any open token and
// adds an end-of-file token, after which line and column restart at 1. A byte
// is registered on entry and scanned once the output queue has room; the scan
// writes its tokens into that queue, whose head drives the master side. A
// token comes from the byte that ends it, normally the byte after its last
// character. Each byte gives zero, one or two tokens; tokens leave through a
// four-entry queue at one per cycle while the master side is ready. A
// registered byte is held, and the slave side stalls behind it, while that
// queue has fewer than two free entries.
// The user writes tab_width through cfg_we/cfg_wdata only while no traffic
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module token_scanner
    import tsc_pkg::*;
#(
    parameter int PREFIX_CHARS  = DEF_PREFIX_CHARS,
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // char_code
    input  logic                 s_axis_tlast,   // end_of_input
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // start_line, start_column, text_length, text_prefix, int_value,
    // error_code, zero padding
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]    m_axis_tuser,   // token_kind
    output logic                 m_axis_tlast,   // last
    input  logic                 cfg_we,
    input  logic [TAB_W-1:0]     cfg_wdata       // tab_width
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        step_en;
    logic        room;
    tsc_push_t   push;
    tsc_result_t head;

    // The registered byte is scanned once the queue can absorb two tokens.
    assign step_en       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    tsc_core #(
        .PREFIX_CHARS  (PREFIX_CHARS),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .step_en      (step_en),
        .char_code    (in_char_reg),
        .end_of_input (in_last_reg),
        .push         (push)
    );

    tsc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_axis_tready),
        .head      (head),
        .not_empty (m_axis_tvalid),
        .room      (room)
    );

    // Pack the head token onto the master side.
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;
    assign m_axis_tdata = M_TDATA_W'({head.error, head.value, head.prefix,
                                      head.length, head.column, head.line});

endmodule

// ----- rtl/tsc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks on the token stream of the scanner, bound to the top.
// ----------------------------------------------------------------------------
`include "token_scanner_macros.svh"

module tsc_checker
    import tsc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]    m_axis_tuser,
    input logic                 m_axis_tlast
);

    logic [ERR_W-1:0] err_field;
    logic [LEN_W-1:0] len_field;
    logic [TEXT_W-1:0] text_field;

    assign err_field  = m_axis_tdata[OFS_ERR +: ERR_W];
    assign len_field  = m_axis_tdata[OFS_LEN +: LEN_W];
    assign text_field = m_axis_tdata[OFS_TEXT +: TEXT_W];

    // Token kinds stay within the defined codes.
    `TSC_ASSERT_IMPLY(a_kind_range, m_axis_tvalid, m_axis_tuser <= KIND_INVALID)

    // End of file is always the final token of its byte.
    `TSC_ASSERT_IMPLY(a_eof_last, m_axis_tvalid && m_axis_tuser == KIND_EOF, m_axis_tlast)

    // Only invalid tokens carry an error code.
    `TSC_ASSERT_IMPLY(a_err_invalid, m_axis_tvalid && err_field != ERR_NONE,
                      m_axis_tuser == KIND_INVALID)

    // Keywords and symbols carry no text.
    `TSC_ASSERT_IMPLY(a_kw_no_text, m_axis_tvalid && m_axis_tuser < KIND_IDENT,
                      len_field == '0 && text_field == '0)

    // A stalled token is held unchanged.
    `TSC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind token_scanner tsc_checker u_tsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/token_scanner_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_scanner_test
// Self-checking bench for the token scanner. Source bytes are streamed in and
// every token that comes out is compared field by field with a behavioral
// scanner kept in the bench or a hand-typed token. A short scripted source
// covers keywords, the misspelled keyword, symbols, number errors, long
// tokens and the end marker. Random sources with varied tab widths and flow
// control follow, then a run of wide tabs with a few tokens after it.
// ----------------------------------------------------------------------------
module token_scanner_test;
    import tsc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 235;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PRINT_LIMIT   = 100;
    localparam int TAB_BURST     = 40;
    localparam int NO_TAIL       = -1;
    localparam int END_MARK      = 256;
    localparam logic [63:0] INT63_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_state_t;

    // One scripted line of source; the tail byte may carry a hand-typed token.
    typedef struct {
        string       text;
        int          tail;
        bit          pinned;
        tsc_result_t want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // char_code
    logic                 s_axis_tlast;   // end_of_input
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // start_line, start_column, text_length, text_prefix, int_value,
    // error_code, zero padding
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;   // token_kind
    logic                 m_axis_tlast;   // last
    logic                 cfg_we;
    logic [TAB_W-1:0]     cfg_wdata;      // tab_width

    // Scanner state mirrored by the bench.
    logic [TAB_W-1:0]  tab_cfg  = TAB_RESET;
    scan_state_t       scan_mode = SCAN_IDLE;
    logic [POS_W-1:0]  line_no  = POS_ONE;
    logic [POS_W-1:0]  col_no   = POS_ONE;
    logic [POS_W-1:0]  tok_line = POS_ONE;
    logic [POS_W-1:0]  tok_col  = POS_ONE;
    logic [LEN_W-1:0]  tok_len  = '0;
    logic [TEXT_W-1:0] tok_text = '0;
    logic [63:0]       acc      = '0;
    bit                ovf_seen;
    bit                dot_seen;
    bit                trail_dot;

    string keyword_spelling [6] = '{"let", "int", "float", "bool", "true", "false"};
    string symbol_set = ":;=+-*/%()";
    string word_head  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_body  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string digit_set  = "0123456789";
    string blank_set  = " \t\n\v\f\r";

    tsc_result_t step_tokens [$];
    tsc_result_t tokens_due [$];
    logic [8:0]  pending_bytes [$];
    script_row_t script [$];

    int mismatch_count;
    int tokens_seen;
    int items_sent;
    int send_idle_pct;
    int stall_pct;
    bit hold_go;
    bit hold_on;

    token_scanner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the scanner hangs.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Behavioral scanner
    // ------------------------------------------------------------------

    function automatic logic blank_byte(input logic [7:0] c);
        return c == 8'h20 || (c >= CH_TAB && c <= 8'h0D);
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic tsc_result_t bare_token(input logic [KIND_W-1:0] kind,
                                               input logic [POS_W-1:0] line,
                                               input logic [POS_W-1:0] col,
                                               input logic [ERR_W-1:0] err);
        tsc_result_t r;
        r = '0;
        r.kind = kind;
        r.line = line;
        r.column = col;
        r.error = err;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void emit(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] line,
                                 input logic [POS_W-1:0] col, input logic [LEN_W-1:0] len,
                                 input logic [TEXT_W-1:0] text,
                                 input logic [INT_W-1:0] value,
                                 input logic [ERR_W-1:0] err);
        tsc_result_t r;
        r.kind = kind;
        r.line = line;
        r.column = col;
        r.length = len;
        r.prefix = text;
        r.value = value;
        r.error = err;
        r.last = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    // Line and column move after every consumed byte.
    function automatic void bump_position(input logic [7:0] c);
        logic [POS_W:0] wide;
        if (c == CH_NL)
        begin
            if (line_no < POS_MAX)
                line_no++;
            col_no = POS_ONE;
        end
        else if (c == CH_TAB)
        begin
            wide = col_no + tab_cfg;
            col_no = (wide > POS_MAX) ? POS_MAX : wide[POS_W-1:0];
        end
        else if (col_no < POS_MAX)
        begin
            col_no++;
        end
    endfunction

    // Only the first bytes are kept; the length saturates.
    function automatic void take_char(input logic [7:0] c);
        if (tok_len < DEF_PREFIX_CHARS)
            tok_text[8*tok_len +: 8] = c;
        if (tok_len < DEF_MAX_TOKEN_LEN)
            tok_len++;
    endfunction

    function automatic void open_token(input logic [7:0] c, input scan_state_t mode);
        tok_line = line_no;
        tok_col = col_no;
        tok_len = '0;
        tok_text = '0;
        acc = '0;
        ovf_seen = 1'b0;
        dot_seen = 1'b0;
        trail_dot = 1'b0;
        scan_mode = mode;
        take_char(c);
    endfunction

    // A finished word is a keyword only on an exact match of text and length.
    function automatic void close_word();
        bit same;
        int i;
        int j;
        scan_mode = SCAN_IDLE;
        for (i = 0; i < 6; i++)
        begin
            same = (tok_len == keyword_spelling[i].len());
            for (j = 0; same && j < keyword_spelling[i].len(); j++)
                if (tok_text[8*j +: 8] != keyword_spelling[i][j])
                    same = 1'b0;
            if (same)
            begin
                emit(KIND_W'(i), tok_line, tok_col, '0, '0, '0, ERR_NONE);
                return;
            end
        end
        emit(KIND_IDENT, tok_line, tok_col, tok_len, tok_text, '0, ERR_NONE);
    endfunction

    // A dangling dot wins over a fraction, which wins over an overflow.
    function automatic void close_number();
        scan_mode = SCAN_IDLE;
        if (trail_dot)
            emit(KIND_INVALID, tok_line, tok_col, tok_len, tok_text, '0, ERR_TRAIL_DOT);
        else if (dot_seen)
            emit(KIND_FLOAT, tok_line, tok_col, tok_len, tok_text, '0, ERR_NONE);
        else if (ovf_seen)
            emit(KIND_INVALID, tok_line, tok_col, tok_len, tok_text, '0, ERR_INT_RANGE);
        else
            emit(KIND_INT, tok_line, tok_col, tok_len, tok_text, acc[INT_W-1:0], ERR_NONE);
    endfunction

    // A byte seen between tokens.
    function automatic void scan_idle(input logic [7:0] c);
        int  i;
        bit  hit;
        hit = 1'b0;
        if (blank_byte(c))
        begin
        end
        else if (letter_byte(c) || c == CH_UNDER)
        begin
            open_token(c, SCAN_WORD);
        end
        else if (digit_byte(c))
        begin
            open_token(c, SCAN_NUMBER);
            acc = {60'd0, c[3:0]};
        end
        else
        begin
            for (i = 0; i < symbol_set.len(); i++)
            begin
                if (!hit && symbol_set[i] == c)
                begin
                    emit(KIND_SYM0 + KIND_W'(i), line_no, col_no, '0, '0, '0, ERR_NONE);
                    hit = 1'b1;
                end
            end
            if (!hit)
                emit(KIND_INVALID, line_no, col_no, '0, '0, '0, ERR_BAD_CHAR);
        end
        bump_position(c);
    endfunction

    // A byte seen inside a numeric literal.
    function automatic void number_byte(input logic [7:0] c);
        logic [63:0] d;
        d = {60'd0, c[3:0]};
        if (digit_byte(c))
        begin
            if (!dot_seen && !ovf_seen)
            begin
                if (acc > (INT63_TOP - d) / 10)
                    ovf_seen = 1'b1;
                else
                    acc = acc * 10 + d;
            end
            trail_dot = 1'b0;
            take_char(c);
            bump_position(c);
        end
        else if (c == CH_DOT && !trail_dot)
        begin
            take_char(c);
            bump_position(c);
            trail_dot = 1'b1;
            if (dot_seen)
                close_number();
            dot_seen = 1'b1;
        end
        else
        begin
            close_number();
            scan_idle(c);
        end
    endfunction

    // Tokens caused by one accepted request, in output order.
    function automatic void scan_predict(input logic [7:0] c, input bit eoi);
        step_tokens.delete();
        if (eoi)
        begin
            if (scan_mode == SCAN_WORD)
                close_word();
            else if (scan_mode == SCAN_NUMBER)
                close_number();
            scan_mode = SCAN_IDLE;
            if (col_no < POS_MAX)
                col_no++;
            emit(KIND_EOF, line_no, col_no, '0, '0, '0, ERR_NONE);
            line_no = POS_ONE;
            col_no = POS_ONE;
        end
        else if (scan_mode == SCAN_WORD)
        begin
            if (letter_byte(c) || digit_byte(c) || c == CH_UNDER)
            begin
                take_char(c);
                bump_position(c);
            end
            else
            begin
                close_word();
                scan_idle(c);
            end
        end
        else if (scan_mode == SCAN_NUMBER)
        begin
            number_byte(c);
        end
        else
        begin
            scan_idle(c);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Token checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] token %0d %s: got 0x%0h, want 0x%0h",
                     $time, tokens_seen, what, got, want);
    endtask

    task automatic check_token();
        tsc_result_t want;
        tokens_seen++;
        if (tokens_due.size() == 0)
        begin
            report_mismatch("unexpected token, kind", m_axis_tuser, '0);
            return;
        end
        want = tokens_due.pop_front();
        if (m_axis_tuser != want.kind)
            report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[OFS_LINE +: POS_W] != want.line)
            report_mismatch("line", m_axis_tdata[OFS_LINE +: POS_W], want.line);
        if (m_axis_tdata[OFS_COL +: POS_W] != want.column)
            report_mismatch("column", m_axis_tdata[OFS_COL +: POS_W], want.column);
        if (m_axis_tdata[OFS_LEN +: LEN_W] != want.length)
            report_mismatch("length", m_axis_tdata[OFS_LEN +: LEN_W], want.length);
        if (m_axis_tdata[OFS_TEXT +: TEXT_W] != want.prefix)
            report_mismatch("prefix", m_axis_tdata[OFS_TEXT +: TEXT_W], want.prefix);
        if (m_axis_tdata[OFS_INT +: INT_W] != want.value)
            report_mismatch("value", m_axis_tdata[OFS_INT +: INT_W], want.value);
        if (m_axis_tdata[OFS_ERR +: ERR_W] != want.error)
            report_mismatch("error", m_axis_tdata[OFS_ERR +: ERR_W], want.error);
        if (m_axis_tlast != want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        if (m_axis_tdata[M_TDATA_W-1:DATA_BITS] != '0)
            report_mismatch("padding", m_axis_tdata[M_TDATA_W-1:DATA_BITS], '0);
    endtask

    // Output side: check on each transfer, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_token();
        m_axis_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end

    // Long output hold-off so the queue fills and the input stalls.
    initial
    begin
        hold_on <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one request after a random gap and predicts once it is taken.
    task automatic send_item(input logic [7:0] c, input bit eoi, input bit pinned,
                             input tsc_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= eoi;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        scan_predict(c, eoi);
        if (pinned)
            tokens_due.insert(tokens_due.size(), want);
        else
            foreach (step_tokens[k])
                tokens_due.insert(tokens_due.size(), step_tokens[k]);
    endtask

    task automatic send_pending();
        logic [8:0] b;
        while (pending_bytes.size() != 0)
        begin
            b = pending_bytes.pop_front();
            send_item(b[7:0], b[8], 1'b0, '0);
        end
    endtask

    // Appends one byte, with its end marker bit on top, to the send list.
    function automatic void queue_byte(input logic [8:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    function automatic void queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte({1'b0, s[i]});
    endfunction

    function automatic void queue_end();
        queue_byte({1'b1, 8'($urandom_range(255))});
    endfunction

    function automatic string random_run(input string charset, input int n);
        string s;
        int    i;
        int    k;
        s = "";
        for (i = 0; i < n; i++)
        begin
            k = $urandom_range(charset.len() - 1);
            s = {s, charset.substr(k, k)};
        end
        return s;
    endfunction

    // One token with random content, or noise, or an end marker, or blanks.
    function automatic void queue_random_token();
        int          pick;
        int          n;
        logic [63:0] big;
        string       s;
        string       frac;
        s = "";
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            n = ($urandom_range(149) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 12);
            s = {random_run(word_head, 1), random_run(word_body, n - 1)};
        end
        else if (pick < 30)
        begin
            n = $urandom_range(6);
            s = (n < 6) ? keyword_spelling[n] : "flase";
        end
        else if (pick < 50)
        begin
            case ($urandom_range(3))
                0: big = {$urandom, $urandom};
                1: big = INT63_TOP - 8 + $urandom_range(16);
                default: big = $urandom_range(999999);
            endcase
            s = $sformatf("%0d", big);
            if ($urandom_range(7) == 0)
                s = {"0", s};
        end
        else if (pick < 62)
        begin
            s = {random_run(digit_set, $urandom_range(1, 4)), "."};
            frac = random_run(digit_set, $urandom_range(1, 3));
            case ($urandom_range(3))
                0: s = {s, frac};
                1: s = s;
                2: s = {s, frac, "."};
                default: s = {s, frac, ".", frac};
            endcase
        end
        else if (pick < 75)
        begin
            n = $urandom_range(symbol_set.len() - 1);
            s = symbol_set.substr(n, n);
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(1, 4))
                queue_byte({1'b0, 8'($urandom_range(255))});
        end
        else if (pick < 93)
        begin
            queue_end();
        end
        else
        begin
            s = random_run(blank_set, $urandom_range(1, 3));
        end
        queue_text(s);
        if ($urandom_range(1))
            queue_text(random_run(blank_set, 1));
    endfunction

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
        begin
            queue_random_token();
            send_pending();
        end
    endtask

    // Waits until every expected token has come or the wait limit runs out, then lets the pipeline settle.
    task automatic drain_tokens();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tokens_due.size() != 0)
        begin
            report_mismatch("tokens never delivered", tokens_due.size(), '0);
            tokens_due.delete();
        end
    endtask

    task automatic set_tab_width(input logic [TAB_W-1:0] w);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        tab_cfg = w;
    endtask

    // Scripted source, run with the reset tab width.
    function automatic void load_script();
        string long_word;
        string long_digits;
        int    i;
        long_word = "";
        long_digits = "";
        for (i = 0; i < 300; i++)
            long_word = {long_word, (i % 3 == 0) ? "_" : "w"};
        for (i = 0; i < 270; i++)
            long_digits = {long_digits, "9"};
        // Symbol right after reset, then the top and bottom byte as bad characters.
        script.insert(script.size(), '{"", 8'h3B, 1'b1,
                      bare_token(KIND_SYM0 + 5'd1, POS_ONE, POS_ONE, ERR_NONE)});
        script.insert(script.size(), '{"", 8'hFF, 1'b1,
                      bare_token(KIND_INVALID, POS_ONE, POS_W'(2), ERR_BAD_CHAR)});
        script.insert(script.size(), '{"\n", 8'h00, 1'b1,
                      bare_token(KIND_INVALID, POS_W'(2), POS_ONE, ERR_BAD_CHAR)});
        // Misspelled keyword, keywords, symbols and all whitespace bytes.
        script.insert(script.size(), '{" flase false)", NO_TAIL, 1'b0, '0});
        script.insert(script.size(), '{"\tlet int float bool true\n", NO_TAIL, 1'b0, '0});
        script.insert(script.size(), '{":;=+-*/%()", NO_TAIL, 1'b0, '0});
        script.insert(script.size(), '{"\v\f\r_a9Z_ x", NO_TAIL, 1'b0, '0});
        // Largest integer, one past it, and far past it.
        script.insert(script.size(),
                      '{"9223372036854775807 9223372036854775808 18446744073709551616 ",
                        NO_TAIL, 1'b0, '0});
        // Decimal, dangling dot, second dot, dot before a letter.
        script.insert(script.size(), '{"3.14 7. 1.2.3 5.x 0.5.", NO_TAIL, 1'b0, '0});
        script.insert(script.size(), '{"00042;id9(", NO_TAIL, 1'b0, '0});
        // Saturating token length.
        script.insert(script.size(), '{{long_word, " ", long_digits, ";"}, NO_TAIL, 1'b0, '0});
        // End marker with an open word, alone, and with open numbers.
        script.insert(script.size(), '{"abc", END_MARK, 1'b0, '0});
        script.insert(script.size(), '{"", END_MARK, 1'b1,
                      bare_token(KIND_EOF, POS_ONE, POS_W'(2), ERR_NONE)});
        script.insert(script.size(), '{"12.", END_MARK, 1'b0, '0});
        script.insert(script.size(), '{"99", END_MARK, 1'b0, '0});
    endfunction

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_go = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        tokens_seen = 0;
        items_sent = 0;
        load_script();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted source.
        foreach (script[r])
        begin
            queue_text(script[r].text);
            if (script[r].tail != NO_TAIL && !script[r].pinned)
            begin
                if (script[r].tail == END_MARK)
                    queue_end();
                else
                    queue_byte({1'b0, 8'(script[r].tail)});
            end
            send_pending();
            if (script[r].pinned)
                send_item(8'(script[r].tail), script[r].tail == END_MARK, 1'b1,
                          script[r].want);
        end
        drain_tokens();

        // Random sources under four flow-control mixes.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    set_tab_width(TAB_W'(0));
                    hold_go = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct = 0;
                    set_tab_width(TAB_W'(16));
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 85;
                    set_tab_width({TAB_W{1'b1}});
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct = 19;
                    set_tab_width(TAB_W'($urandom_range(1, 15)));
                end
            endcase
            run_random(PHASE_ITEMS);
            drain_tokens();
        end

        // A run of wide tabs, then tokens far to the right.
        send_idle_pct = 0;
        stall_pct = 0;
        set_tab_width({TAB_W{1'b1}});
        queue_text("x");
        repeat (TAB_BURST)
            queue_byte({1'b0, CH_TAB});
        queue_text("ab 7 ;\t.1.5 q\nz9 ");
        queue_end();
        send_pending();
        drain_tokens();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
